// ===== sv/mrr_pkg.sv =====
// mrr_pkg: shared types and codes for the matrix ring rotator
// no dependencies; imported by every module of the block
package mrr_pkg;

    localparam int DATA_W  = 32;
    localparam int COORD_W = 6;   // holds any count or coordinate in use
    localparam int LEN_W   = 8;   // ring length, at most 2*(62+62)
    localparam int COUNT_MAX = (1 << COORD_W) - 1;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_ROTATE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COORD = 2'd1;
    localparam logic [1:0] ST_RING  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi_r;
        logic [COORD_W-1:0] hi_c;
    } t_ring_bounds;

endpackage

// ===== sv/mrr_mod_unit.sv =====
// mrr_mod_unit: iterative remainder of a 32-bit magnitude by the ring length
// one quotient bit per cycle; depends on mrr_pkg
module mrr_mod_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [mrr_pkg::DATA_W-1:0] i_dividend,
    input  logic [mrr_pkg::LEN_W-1:0]  i_len,
    output logic                     o_done,
    output logic [mrr_pkg::LEN_W-1:0]  o_rem
);
    import mrr_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [DATA_W-1:0] r_dvd;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_dvd[DATA_W-1]};
    assign fits  = (trial >= {1'b0, i_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
            // partial remainder stays below the length, so trial < 2*len
            r_rem <= fits ? LEN_W'(trial - {1'b0, i_len}) : trial[LEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/mrr_ring_walk.sv =====
// mrr_ring_walk: steps a coordinate pair around one ring and forms its address
// order: down left column, along bottom row, up right column, back along top; uses mrr_pkg
module mrr_ring_walk #(
    parameter int MAX_COLS = 32,
    parameter int ADDR_W   = 10
) (
    input  logic                  i_clk,
    input  logic                  i_start,
    input  logic                  i_step,
    input  mrr_pkg::t_ring_bounds i_bounds,
    output logic [ADDR_W-1:0]     o_addr
);
    import mrr_pkg::*;

    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_col, n_col;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_start) begin
            n_row = i_bounds.lo;
            n_col = i_bounds.lo;
        end else if (i_step) begin
            if (r_col == i_bounds.lo && r_row != i_bounds.hi_r) begin
                n_row = r_row + COORD_W'(1);
            end else if (r_row == i_bounds.hi_r && r_col != i_bounds.hi_c) begin
                n_col = r_col + COORD_W'(1);
            end else if (r_col == i_bounds.hi_c && r_row != i_bounds.lo) begin
                n_row = r_row - COORD_W'(1);
            end else begin
                n_col = r_col - COORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
    end

    assign o_addr = ADDR_W'(32'(r_row) * MAX_COLS + 32'(r_col));

endmodule

// ===== sv/matrix_ring_rotator.sv =====
// matrix_ring_rotator: element store with ring rotation, APB configuration
// throughput: one transfer at a time; a rotate runs the 32-step remainder unit, then
//   one gather pass and one scatter pass over the element memory
// reset: synchronous active low; counts return to 32, element memory is not cleared
// uses mrr_pkg, mrr_mod_unit, mrr_ring_walk
module matrix_ring_rotator #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_action,
    input  logic [4:0]                 i_row_index,
    input  logic [4:0]                 i_col_index,
    input  logic signed [31:0]         i_write_value,
    input  logic [4:0]                 i_ring_number,
    input  logic signed [31:0]         i_shift_amount,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [31:0]         o_read_value,
    output logic [1:0]                 o_status
);
    import mrr_pkg::*;

    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int EFF_ROWS   = (MAX_ROWS < COUNT_MAX) ? MAX_ROWS : COUNT_MAX;
    localparam int EFF_COLS   = (MAX_COLS < COUNT_MAX) ? MAX_COLS : COUNT_MAX;
    localparam int RING_DEPTH = 2 * (EFF_ROWS + EFF_COLS - 2);
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_READ    = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_KFIX    = 4'd3;
    localparam logic [3:0] S_GATHER  = 4'd4;
    localparam logic [3:0] S_GDRAIN  = 4'd5;
    localparam logic [3:0] S_SCATTER = 4'd6;
    localparam logic [3:0] S_SDRAIN  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]         r_state;
    logic [COORD_W-1:0] r_row_count;
    logic [COORD_W-1:0] r_col_count;
    logic               r_out_valid;
    logic               r_gw;
    logic               r_sw;
    logic [LEN_W-1:0]   r_cnt;
    logic [LEN_W-1:0]   r_q;

    t_ring_bounds       r_bounds;
    logic [LEN_W-1:0]   r_len;
    logic               r_neg;
    logic [DATA_W-1:0]  r_res_value;
    logic [1:0]         r_res_status;
    logic [DATA_W-1:0]  r_out_value;
    logic [1:0]         r_out_status;
    logic [RING_AW-1:0] r_gidx;
    logic [ADDR_W-1:0]  r_saddr;

    logic [DATA_W-1:0]  mem_m [DEPTH];
    logic [DATA_W-1:0]  r_m_q;
    logic [DATA_W-1:0]  mem_b [RING_DEPTH];
    logic [DATA_W-1:0]  r_b_q;

    logic               cfg_wr;
    logic               in_fire;
    logic               out_load;
    logic [COORD_W-1:0] rows_use;
    logic [COORD_W-1:0] cols_use;
    logic               coord_ok;
    logic               ring_ok;
    logic [ADDR_W-1:0]  in_addr;
    t_ring_bounds       in_bounds;
    logic [COORD_W-1:0] span_h;
    logic [COORD_W-1:0] span_w;
    logic [LEN_W-2:0]   half_len;
    logic [DATA_W-1:0]  shift_mag;
    logic               mod_done;
    logic [LEN_W-1:0]   mod_rem;
    logic [LEN_W-1:0]   k_start;
    logic               walk_start;
    logic               walk_step;
    logic [ADDR_W-1:0]  walk_addr;
    logic               last_elem;
    logic [LEN_W-1:0]   q_next;

    logic               m_we;
    logic [ADDR_W-1:0]  m_waddr;
    logic [DATA_W-1:0]  m_wdata;
    logic               m_re;
    logic [ADDR_W-1:0]  m_raddr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {(32 - COORD_W)'(0), r_col_count}
                             : {(32 - COORD_W)'(0), r_row_count};

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // sizes in use and checks on the incoming transfer
    assign rows_use = (32'(r_row_count) > MAX_ROWS) ? COORD_W'(MAX_ROWS) : r_row_count;
    assign cols_use = (32'(r_col_count) > MAX_COLS) ? COORD_W'(MAX_COLS) : r_col_count;
    assign coord_ok = ({1'b0, i_row_index} < rows_use) && ({1'b0, i_col_index} < cols_use);
    assign ring_ok  = (i_ring_number != 5'd0) &&
                      ({i_ring_number, 1'b0} <= rows_use) &&
                      ({i_ring_number, 1'b0} <= cols_use);
    assign in_addr  = ADDR_W'(32'(i_row_index) * MAX_COLS + 32'(i_col_index));

    assign in_bounds.lo   = COORD_W'(i_ring_number) - COORD_W'(1);
    assign in_bounds.hi_r = rows_use - COORD_W'(i_ring_number);
    assign in_bounds.hi_c = cols_use - COORD_W'(i_ring_number);
    assign span_h   = in_bounds.hi_r - in_bounds.lo;
    assign span_w   = in_bounds.hi_c - in_bounds.lo;
    assign half_len = (LEN_W - 1)'(span_h) + (LEN_W - 1)'(span_w);
    assign shift_mag = i_shift_amount[DATA_W-1] ? (~i_shift_amount + 32'sd1)
                                                : i_shift_amount;

    mrr_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire && i_action == ACT_ROTATE && ring_ok),
        .i_dividend (shift_mag),
        .i_len      (r_len),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // truncating remainder carries the sign of the shift; fold into 0..L-1
    assign k_start = (r_neg && mod_rem != '0) ? (r_len - mod_rem) : mod_rem;

    assign walk_start = (r_state == S_KFIX) || (r_state == S_GDRAIN);
    assign walk_step  = (r_state == S_GATHER) || (r_state == S_SCATTER);

    mrr_ring_walk #(
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_walk (
        .i_clk    (i_clk),
        .i_start  (walk_start),
        .i_step   (walk_step),
        .i_bounds (r_bounds),
        .o_addr   (walk_addr)
    );

    assign last_elem = (r_cnt == r_len - LEN_W'(1));
    assign q_next    = (r_q == r_len - LEN_W'(1)) ? '0 : (r_q + LEN_W'(1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= COORD_W'(32);
            r_col_count <= COORD_W'(32);
            r_out_valid <= 1'b0;
            r_gw        <= 1'b0;
            r_sw        <= 1'b0;
            r_cnt       <= '0;
            r_q         <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_col_count <= pwdata[COORD_W-1:0];
                end else begin
                    r_row_count <= pwdata[COORD_W-1:0];
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            r_gw <= (r_state == S_GATHER);
            r_sw <= (r_state == S_SCATTER);

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_action == ACT_READ && coord_ok) begin
                            r_state <= S_READ;
                        end else if (i_action == ACT_ROTATE && ring_ok) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: r_state <= S_DONE;
                S_DIV: begin
                    if (mod_done) begin
                        r_state <= S_KFIX;
                    end
                end
                S_KFIX: begin
                    r_q     <= k_start;
                    r_cnt   <= '0;
                    r_state <= S_GATHER;
                end
                S_GATHER: begin
                    r_q <= q_next;
                    if (last_elem) begin
                        r_cnt   <= '0;
                        r_state <= S_GDRAIN;
                    end else begin
                        r_cnt <= r_cnt + LEN_W'(1);
                    end
                end
                S_GDRAIN: r_state <= S_SCATTER;
                S_SCATTER: begin
                    r_cnt <= r_cnt + LEN_W'(1);
                    if (last_elem) begin
                        r_state <= S_SDRAIN;
                    end
                end
                S_SDRAIN: r_state <= S_DONE;
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_bounds     <= in_bounds;
            r_len        <= {half_len, 1'b0};
            r_neg        <= i_shift_amount[DATA_W-1];
            r_res_value  <= '0;
            if ((i_action == ACT_WRITE || i_action == ACT_READ) && !coord_ok) begin
                r_res_status <= ST_COORD;
            end else if (i_action == ACT_ROTATE && !ring_ok) begin
                r_res_status <= ST_RING;
            end else begin
                r_res_status <= ST_OK;
            end
        end
        if (r_state == S_READ) begin
            r_res_value <= r_m_q;
        end
        if (r_state == S_GATHER) begin
            r_gidx <= r_q[RING_AW-1:0];
        end
        if (r_state == S_SCATTER) begin
            r_saddr <= walk_addr;
        end
        if (out_load) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    // element memory: one write and one read port, registered read data
    assign m_we    = (in_fire && i_action == ACT_WRITE && coord_ok) || r_sw;
    assign m_waddr = r_sw ? r_saddr : in_addr;
    assign m_wdata = r_sw ? r_b_q : i_write_value;
    assign m_re    = (in_fire && i_action == ACT_READ && coord_ok) || (r_state == S_GATHER);
    assign m_raddr = (r_state == S_GATHER) ? walk_addr : in_addr;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem_m[m_waddr] <= m_wdata;
        end
        if (m_re) begin
            r_m_q <= mem_m[m_raddr];
        end
    end

    // ring buffer: gathered elements land at their rotated position
    always_ff @(posedge i_clk) begin
        if (r_gw) begin
            mem_b[r_gidx] <= r_m_q;
        end
        if (r_state == S_SCATTER) begin
            r_b_q <= mem_b[r_cnt[RING_AW-1:0]];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

// ===== sv/mrr_checker.sv =====
// mrr_checker: port-level assertions for matrix_ring_rotator, with its bind
// depends on mrr_pkg and the top level's port names
module mrr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               i_in_valid,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_read_value,
    input logic [1:0]         o_status
);
    import mrr_pkg::*;

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
                                        && $stable(o_status))
        else $error("result changed while stalled");

    // a failed action never carries data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_read_value == 32'sd0)
        else $error("nonzero value with error status");

    // one transfer in flight: ready drops right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer accepted too early");

endmodule

bind matrix_ring_rotator mrr_checker u_mrr_checker (.*);
